// File: rtl/cppd_pkg.sv
// ----------------------------------------------------------------------------
// cppd_pkg
// Shared types and constants for the column-post picture decoder.
// ----------------------------------------------------------------------------
package cppd_pkg;

    localparam int MAX_DIMENSION_DEF   = 640;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int COORD_W = 10;
    localparam int BYTE_W  = 8;
    localparam int RGB_W   = 24;
    localparam int ADDR_W  = 19;
    localparam int ARGB_W  = 32;
    localparam int PROD_W  = 2 * COORD_W;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [COORD_W-1:0] IMAGE_WIDTH_RST  = 10'd320;
    localparam logic [COORD_W-1:0] IMAGE_HEIGHT_RST = 10'd200;

    localparam logic [BYTE_W-1:0] END_OF_COLUMN = 8'hFF;
    localparam logic [7:0]        ALPHA_OPAQUE  = 8'hFF;

    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_COLUMN  = 1'b1;

    typedef enum logic [2:0] {
        PH_TOP,
        PH_LEN,
        PH_PAD,
        PH_PIX,
        PH_TRAIL,
        PH_DONE
    } cppd_phase_t;

    // Pixel stage between the parser and the address/output stage
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               oob;
    } cppd_pix_t;

endpackage

// File: rtl/cppd_palette.sv
// ----------------------------------------------------------------------------
// cppd_palette
// Palette memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cppd_palette
    import cppd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [BYTE_W-1:0] wr_index,
    input  logic [RGB_W-1:0]  wr_rgb,
    input  logic              rd_en,
    input  logic [BYTE_W-1:0] rd_index,
    output logic [RGB_W-1:0]  rd_rgb,
    output logic              rd_hit
);

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [BYTE_W:0] PAL_LIMIT = (BYTE_W+1)'(PALETTE_ENTRIES);

    logic [RGB_W-1:0] mem [PALETTE_ENTRIES];
    logic [RGB_W-1:0] rd_rgb_reg;
    logic             rd_hit_reg;
    logic             wr_hit;
    logic             rd_hit_next;

    assign wr_hit      = {1'b0, wr_index} < PAL_LIMIT;
    assign rd_hit_next = {1'b0, rd_index} < PAL_LIMIT;

    // Drop writes beyond the table
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_hit)
        begin
            mem[wr_index[PAL_AW-1:0]] <= wr_rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_rgb_reg <= mem[rd_index[PAL_AW-1:0]];
            rd_hit_reg <= rd_hit_next;
        end
    end

    assign rd_rgb = rd_rgb_reg;
    assign rd_hit = rd_hit_reg;

endmodule

// File: rtl/cppd_parser.sv
// ----------------------------------------------------------------------------
// cppd_parser
// Post parsing state machine and the registered pixel stage.
// ----------------------------------------------------------------------------
module cppd_parser
    import cppd_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_accept,
    input  logic               action,
    input  logic [COORD_W-1:0] column,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               first_in_column,
    input  logic               last_in_column,
    input  logic [COORD_W-1:0] image_width,
    input  logic [COORD_W-1:0] image_height,
    input  logic               stage_pop,
    output cppd_pix_t          pix
);

    localparam logic [COORD_W:0] DIM_LIMIT = (COORD_W+1)'(MAX_DIMENSION);

    cppd_phase_t        phase_reg, phase_next, phase_eff;
    logic [COORD_W-1:0] row_reg, row_next, row_eff;
    logic [BYTE_W-1:0]  left_reg, left_next, left_eff;
    logic               size_ok;
    logic               emit;
    logic               pix_valid_reg, pix_valid_next;
    logic [COORD_W-1:0] pix_column_reg;
    logic [COORD_W-1:0] pix_row_reg;
    logic               pix_oob_reg;
    logic               row_oob;

    assign size_ok = (image_width != '0) && ({1'b0, image_width} <= DIM_LIMIT) &&
                     (image_height != '0) && ({1'b0, image_height} <= DIM_LIMIT);

    // A first byte restarts the column before it is parsed
    assign phase_eff = first_in_column ? PH_TOP : phase_reg;
    assign row_eff   = first_in_column ? '0 : row_reg;
    assign left_eff  = first_in_column ? '0 : left_reg;

    assign row_oob = (row_eff >= image_height) || ({1'b0, row_eff} >= DIM_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TOP;
            row_reg       <= '0;
            left_reg      <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        if (item_accept && (action == ACT_COLUMN) && size_ok)
        begin
            phase_next = phase_eff;
            row_next   = row_eff;
            left_next  = left_eff;
            unique case (phase_eff)
                PH_TOP:
                begin
                    if (!last_in_column)
                    begin
                        if (data_byte == END_OF_COLUMN)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            row_next   = COORD_W'(data_byte);
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    left_next  = data_byte;
                    phase_next = PH_PAD;
                end
                PH_PAD:
                begin
                    phase_next = (left_eff == '0) ? PH_TRAIL : PH_PIX;
                end
                PH_PIX:
                begin
                    emit      = 1'b1;
                    row_next  = row_eff + COORD_W'(1);
                    left_next = left_eff - BYTE_W'(1);
                    if (left_eff == BYTE_W'(1))
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
                PH_TRAIL:
                begin
                    phase_next = PH_TOP;
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end
    end

    // Hold the pixel stage while the output side is stalled
    always_comb
    begin
        if (item_accept)
        begin
            pix_valid_next = emit;
        end
        else if (stage_pop)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            pix_column_reg <= column;
            pix_row_reg    <= row_eff;
            pix_oob_reg    <= row_oob;
        end
    end

    assign pix.valid  = pix_valid_reg;
    assign pix.column = pix_column_reg;
    assign pix.row    = pix_row_reg;
    assign pix.oob    = pix_oob_reg;

endmodule

// File: rtl/cppd_out.sv
// ----------------------------------------------------------------------------
// cppd_out
// Address multiply-add and the output register of the master side.
// ----------------------------------------------------------------------------
module cppd_out
    import cppd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cppd_pix_t            pix,
    input  logic [RGB_W-1:0]     pal_rgb,
    input  logic                 pal_hit,
    input  logic [COORD_W-1:0]   image_width,
    output logic                 stage_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_column_reg;
    logic [COORD_W-1:0]   out_row_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [ARGB_W-1:0]    out_argb_reg;
    logic                 out_oob_reg;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    addr_sum;
    logic [ARGB_W-1:0]    argb;

    assign stage_pop = !out_valid_reg || m_tready;

    assign prod     = PROD_W'(pix.row) * PROD_W'(image_width);
    assign addr_sum = prod + PROD_W'(pix.column);
    assign argb     = {ALPHA_OPAQUE, (pal_hit ? pal_rgb : '0)};

    assign out_valid_next = stage_pop ? pix.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_pop && pix.valid)
        begin
            out_column_reg <= pix.column;
            out_row_reg    <= pix.row;
            out_addr_reg   <= addr_sum[ADDR_W-1:0];
            out_argb_reg   <= argb;
            out_oob_reg    <= pix.oob;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_oob_reg, out_argb_reg, out_addr_reg, out_row_reg, out_column_reg};

endmodule

// File: rtl/column_post_picture_decoder.sv
// ----------------------------------------------------------------------------
// column_post_picture_decoder
// Turns palette writes and column-post bytes into pixel write transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per transaction. s_tuser = 0 writes a
//   palette entry, s_tuser = 1 delivers a column byte; s_tlast marks the
//   final byte of a column. Each pixel index byte of a post yields one
//   master transaction; all other items yield none.
//   A pixel reaches the master side through the palette read register and
//   pixel stage, then the output register that takes row * width + column.
//   Throughput: one item per cycle unless both pixel stages are full.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets image_width
//   and image_height; write it only while the block is idle.
//   Reset clears the parsing state and both pipeline stages, and loads
//   width 320 and height 200. The palette is not cleared: write each entry
//   before a pixel refers to it.
//   When m_tready is low, the output register holds and one more pixel can
//   wait in the stage before it; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module column_post_picture_decoder
    import cppd_pkg::*;
#(
    parameter int MAX_DIMENSION   = MAX_DIMENSION_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // column[9:0], data_byte[17:10], first_in_column[18],
    // palette_index[26:19], palette_rgb[50:27], zero fill [55:51]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // action[0]
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_column[9:0], pixel_row[19:10], pixel_address[38:20],
    // argb[70:39], out_of_bounds[71]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    logic [COORD_W-1:0] image_width_reg, image_width_next;
    logic [COORD_W-1:0] image_height_reg, image_height_next;
    logic               item_accept;
    logic               stage_pop;
    cppd_pix_t          pix;
    logic [RGB_W-1:0]   pal_rgb;
    logic               pal_hit;
    logic               size_ok;

    logic [COORD_W-1:0] in_column;
    logic [BYTE_W-1:0]  in_data_byte;
    logic               in_first;
    logic [BYTE_W-1:0]  in_palette_index;
    logic [RGB_W-1:0]   in_palette_rgb;

    assign in_column        = s_tdata[9:0];
    assign in_data_byte     = s_tdata[17:10];
    assign in_first         = s_tdata[18];
    assign in_palette_index = s_tdata[26:19];
    assign in_palette_rgb   = s_tdata[50:27];

    assign s_tready    = !pix.valid || stage_pop;
    assign item_accept = s_tvalid && s_tready;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:          image_width_next  = image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    cppd_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .wr_en    (item_accept && (s_tuser == ACT_PALETTE)),
        .wr_index (in_palette_index),
        .wr_rgb   (in_palette_rgb),
        .rd_en    (item_accept && (s_tuser == ACT_COLUMN)),
        .rd_index (in_data_byte),
        .rd_rgb   (pal_rgb),
        .rd_hit   (pal_hit)
    );

    cppd_parser #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_accept     (item_accept),
        .action          (s_tuser),
        .column          (in_column),
        .data_byte       (in_data_byte),
        .first_in_column (in_first),
        .last_in_column  (s_tlast),
        .image_width     (image_width_reg),
        .image_height    (image_height_reg),
        .stage_pop       (stage_pop),
        .pix             (pix)
    );

    cppd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix),
        .pal_rgb     (pal_rgb),
        .pal_hit     (pal_hit),
        .image_width (image_width_reg),
        .stage_pop   (stage_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    assign size_ok = (image_width_reg != '0) &&
                     ({1'b0, image_width_reg} <= (COORD_W+1)'(MAX_DIMENSION)) &&
                     (image_height_reg != '0) &&
                     ({1'b0, image_height_reg} <= (COORD_W+1)'(MAX_DIMENSION));

    // A palette write never produces a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (s_tuser == ACT_PALETTE) |=> !pix.valid)
        else $error("palette write produced a pixel");

    // Column bytes are ignored while the picture size is invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (s_tuser == ACT_COLUMN) && !size_ok |=> !pix.valid)
        else $error("pixel produced with invalid picture size");

    // A stalled pixel stage holds its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && !stage_pop |=> pix.valid && $stable(pix.row) && $stable(pix.column))
        else $error("pixel stage lost a pixel under stall");

endmodule

// File: test/tb_column_post_picture_decoder.sv
// ----------------------------------------------------------------------------
// tb_column_post_picture_decoder
// Drives palette writes and column-post bytes into the decoder under random
// idling on both stream sides and checks every pixel write it emits against
// an in-bench decoder that tracks the palette, the post parser and the
// picture size. Runs a directed opening and several random phases over
// different picture sizes, invalid sizes included.
// ----------------------------------------------------------------------------
module tb_column_post_picture_decoder;
    import cppd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] column;
        logic [BYTE_W-1:0]  data;
        logic               first;
        logic               last;
        logic [BYTE_W-1:0]  pidx;
        logic [RGB_W-1:0]   rgb;
    } stream_item_t;

    typedef struct packed {
        cppd_phase_t        phase;
        logic [COORD_W-1:0] row;
        logic [BYTE_W-1:0]  left;
    } post_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [ADDR_W-1:0]  addr;
        logic [ARGB_W-1:0]  argb;
        logic               oob;
    } pixel_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data  = '0;

    // Decoder image in the bench
    logic [RGB_W-1:0]   palette_rgb_mem [PALETTE_ENTRIES_DEF];
    post_state_t        parse_state;
    logic [COORD_W-1:0] img_width;
    logic [COORD_W-1:0] img_height;
    pixel_t             expected_pixels [$];

    // Stimulus planning: parser copy used to keep pixel reads on written entries
    post_state_t        plan_state;
    bit                 palette_written [PALETTE_ENTRIES_DEF];
    logic [BYTE_W-1:0]  written_list [$];
    stream_item_t       pending_items [$];
    int                 items_queued;
    int                 useful_items;

    stream_item_t cur_item;
    bit           s_fired;
    int           items_taken;
    int           results_seen;
    int           failures;
    bit           calm;
    int           s_gap;
    int           m_gap;
    int           hold_left;
    bit           long_hold_done;

    column_post_picture_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // One column byte through the post parser; returns 1 when it is a pixel index
    function automatic bit step_post(inout post_state_t st,
                                     input logic [COORD_W-1:0] w,
                                     input logic [COORD_W-1:0] h,
                                     input logic first,
                                     input logic last,
                                     input logic [BYTE_W-1:0] b,
                                     output logic [COORD_W-1:0] row);
        bit pix;
        pix = 1'b0;
        row = st.row;
        if (w == 0 || w > MAX_DIMENSION_DEF || h == 0 || h > MAX_DIMENSION_DEF)
            return 1'b0;
        if (first)
        begin
            st.phase = PH_TOP;
            st.row   = '0;
            st.left  = '0;
            row      = '0;
        end
        case (st.phase)
            PH_TOP:
            begin
                // a closing byte never opens a post
                if (!last)
                begin
                    if (b == END_OF_COLUMN)
                        st.phase = PH_DONE;
                    else
                    begin
                        st.row   = {2'b00, b};
                        st.phase = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                st.left  = b;
                st.phase = PH_PAD;
            end
            PH_PAD:   st.phase = (st.left == 0) ? PH_TRAIL : PH_PIX;
            PH_PIX:
            begin
                pix     = 1'b1;
                row     = st.row;
                st.row  = st.row + 1'b1;
                st.left = st.left - 1'b1;
                if (st.left == 0)
                    st.phase = PH_TRAIL;
            end
            PH_TRAIL: st.phase = PH_TOP;
            default:  ;
        endcase
        return pix;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Sample both handshakes and check pixel writes
    always @(posedge clk)
    begin : monitor
        logic [COORD_W-1:0] row;
        logic [31:0]        sum;
        pixel_t             want;
        pixel_t             got;
        s_fired = rst_n && s_tvalid && s_tready;
        if (s_fired)
        begin
            items_taken++;
            if (cur_item.action == ACT_PALETTE)
                palette_rgb_mem[cur_item.pidx] = cur_item.rgb;
            else if (step_post(parse_state, img_width, img_height, cur_item.first,
                               cur_item.last, cur_item.data, row))
            begin
                sum         = row * img_width + cur_item.column;
                want.column = cur_item.column;
                want.row    = row;
                want.addr   = sum[ADDR_W-1:0];
                want.argb   = {ALPHA_OPAQUE, palette_rgb_mem[cur_item.data]};
                want.oob    = (row >= img_height) || (row >= MAX_DIMENSION_DEF);
                expected_pixels.push_back(want);
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.column = m_tdata[9:0];
            got.row    = m_tdata[19:10];
            got.addr   = m_tdata[38:20];
            got.argb   = m_tdata[70:39];
            got.oob    = m_tdata[71];
            if (expected_pixels.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected pixel write, expected none, got 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("out_column", want.column, got.column);
                check_field("pixel_row", want.row, got.row);
                check_field("pixel_address", want.addr, got.addr);
                check_field("argb", want.argb, got.argb);
                check_field("out_of_bounds", want.oob, got.oob);
            end
        end
    end

    // Input side: hold a transaction until taken, otherwise idle or advance
    always @(negedge clk)
    begin : sender
        logic v;
        v = 1'b0;
        if (rst_n && (!s_tvalid || s_fired))
        begin
            if (s_gap > 0)
                s_gap--;
            else if (!calm && $urandom_range(0, 7) == 0)
                s_gap = $urandom_range(0, 14);
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                v        = 1'b1;
            end
            s_tvalid <= v;
            if (v)
            begin
                s_tdata <= {5'b0, cur_item.rgb, cur_item.pidx, cur_item.first,
                            cur_item.data, cur_item.column};
                s_tuser <= cur_item.action;
                s_tlast <= cur_item.last;
            end
        end
    end

    // Output side: random stalls plus one long hold-off to back up the input
    always @(negedge clk)
    begin : receiver
        logic r;
        r = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (!long_hold_done && results_seen >= 60)
            begin
                long_hold_done = 1'b1;
                hold_left      = 400;
            end
            else if (m_gap > 0)
                m_gap--;
            else if (!calm && $urandom_range(0, 7) == 0)
                m_gap = $urandom_range(0, 14);
            else
                r = 1'b1;
        end
        m_tready <= r;
    end

    task automatic push_item(input stream_item_t it);
        post_state_t        prev_state;
        logic [COORD_W-1:0] row;
        bit                 pix;
        if (it.action == ACT_PALETTE)
        begin
            if (!palette_written[it.pidx])
            begin
                palette_written[it.pidx] = 1'b1;
                written_list.push_back(it.pidx);
            end
            useful_items++;
        end
        else
        begin
            prev_state = plan_state;
            pix = step_post(plan_state, img_width, img_height, it.first, it.last,
                            it.data, row);
            // never point a pixel at an entry that was not loaded
            if (pix && !palette_written[it.data])
                it.data = written_list[$urandom_range(0, written_list.size() - 1)];
            if (pix || plan_state != prev_state)
                useful_items++;
        end
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_palette(input logic [BYTE_W-1:0] idx, input logic [RGB_W-1:0] rgb);
        stream_item_t it;
        it        = '0;
        it.action = ACT_PALETTE;
        it.column = COORD_W'($urandom_range(0, 639));
        it.data   = BYTE_W'($urandom);
        it.first  = 1'($urandom);
        it.last   = 1'($urandom);
        it.pidx   = idx;
        it.rgb    = rgb;
        push_item(it);
    endtask

    task automatic push_byte(input logic [COORD_W-1:0] col, input logic [BYTE_W-1:0] b,
                             input logic first, input logic last);
        stream_item_t it;
        it.action = ACT_COLUMN;
        it.column = col;
        it.data   = b;
        it.first  = first;
        it.last   = last;
        it.pidx   = BYTE_W'($urandom);
        it.rgb    = RGB_W'($urandom);
        push_item(it);
    endtask

    // Well-formed column with random content, sometimes cut short
    task automatic gen_column();
        logic [COORD_W-1:0] col;
        int                 posts;
        int                 len;
        int                 t;
        bit                 broken;
        col    = COORD_W'($urandom_range(0, 639));
        posts  = $urandom_range(0, 3);
        broken = ($urandom_range(0, 9) == 0);
        for (int p = 0; p < posts; p++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                t = int'(img_height) - int'($urandom_range(0, 2));
                if (t < 0)
                    t = 0;
                if (t > 254)
                    t = $urandom_range(200, 254);
            end
            else
                t = $urandom_range(0, 254);
            push_byte(col, BYTE_W'(t), p == 0, 1'b0);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
            push_byte(col, BYTE_W'(len), 1'b0, 1'b0);
            push_byte(col, BYTE_W'($urandom), 1'b0, 1'b0);
            for (int k = 0; k < len; k++)
            begin
                if (broken && $urandom_range(0, 7) == 0)
                    return;
                push_byte(col, BYTE_W'($urandom), 1'b0, 1'b0);
            end
            push_byte(col, BYTE_W'($urandom), 1'b0, 1'b0);
        end
        if (posts == 0 || $urandom_range(0, 1) == 1)
            push_byte(col, END_OF_COLUMN, posts == 0, 1'b0);
        push_byte(col, BYTE_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic gen_random(input int n);
        int start;
        int sel;
        stream_item_t it;
        useful_items = 0;
        start        = items_queued;
        // cap raw items so phases with an invalid size still end
        while (useful_items < n && items_queued - start < 4 * n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                push_palette(BYTE_W'($urandom), RGB_W'($urandom));
            else if (sel < 20)
            begin
                it.action = 1'($urandom);
                it.column = COORD_W'($urandom_range(0, 639));
                it.data   = BYTE_W'($urandom);
                it.first  = ($urandom_range(0, 3) == 0);
                it.last   = ($urandom_range(0, 3) == 0);
                it.pidx   = BYTE_W'($urandom);
                it.rgb    = RGB_W'($urandom);
                push_item(it);
            end
            else
                gen_column();
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_width = val;
        else if (idx == REG_IMAGE_HEIGHT)
            img_height = val;
    endtask

    // Drain everything, then let non-pixel items clear the pipeline
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_pixels.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        img_width   = IMAGE_WIDTH_RST;
        img_height  = IMAGE_HEIGHT_RST;
        parse_state = '{PH_TOP, '0, '0};
        plan_state  = '{PH_TOP, '0, '0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset size
        push_palette(8'd0, 24'h000000);
        push_palette(8'd255, 24'hFFFFFF);
        push_palette(8'h5A, 24'h12A5C3);
        push_byte(10'd639, 8'd0, 1'b1, 1'b0);
        push_byte(10'd639, 8'd2, 1'b0, 1'b0);
        push_byte(10'd639, 8'h00, 1'b0, 1'b0);
        push_byte(10'd639, 8'd255, 1'b0, 1'b0);
        push_byte(10'd639, 8'd0, 1'b0, 1'b0);
        push_byte(10'd639, 8'h00, 1'b0, 1'b0);
        // post straddling the bottom edge of the picture
        push_byte(10'd639, 8'd199, 1'b0, 1'b0);
        push_byte(10'd639, 8'd2, 1'b0, 1'b0);
        push_byte(10'd639, 8'hFF, 1'b0, 1'b0);
        push_byte(10'd639, 8'h5A, 1'b0, 1'b0);
        push_byte(10'd639, 8'd255, 1'b0, 1'b0);
        push_byte(10'd639, 8'hFF, 1'b0, 1'b0);
        // closing byte in top-row phase, then parsing goes on
        push_byte(10'd639, 8'h07, 1'b0, 1'b1);
        push_byte(10'd639, 8'd254, 1'b0, 1'b0);
        push_byte(10'd639, 8'd0, 1'b0, 1'b0);
        push_byte(10'd639, 8'h00, 1'b0, 1'b0);
        push_byte(10'd639, 8'h00, 1'b0, 1'b0);
        push_byte(10'd639, END_OF_COLUMN, 1'b0, 1'b0);
        push_byte(10'd639, 8'h33, 1'b0, 1'b0);
        // restart in the middle of a post
        push_byte(10'd0, 8'd10, 1'b1, 1'b0);
        push_byte(10'd0, 8'd3, 1'b0, 1'b0);
        push_byte(10'd0, 8'h00, 1'b0, 1'b0);
        push_byte(10'd0, 8'd0, 1'b0, 1'b0);
        push_byte(10'd0, END_OF_COLUMN, 1'b1, 1'b1);

        gen_random(500);

        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd640);
        write_reg(REG_IMAGE_HEIGHT, 10'd640);
        @(posedge clk);
        gen_random(300);

        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd1);
        write_reg(REG_IMAGE_HEIGHT, 10'd1);
        @(posedge clk);
        gen_random(200);

        // zero width: column bytes ignored, palette writes still land
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd0);
        write_reg(REG_IMAGE_HEIGHT, 10'd640);
        @(posedge clk);
        gen_random(20);

        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd640);
        write_reg(REG_IMAGE_HEIGHT, 10'd1023);
        @(posedge clk);
        gen_random(20);

        // writes to unused indexes must leave the size alone
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, COORD_W'($urandom_range(1, 640)));
        write_reg(REG_IMAGE_HEIGHT, COORD_W'($urandom_range(1, 640)));
        write_reg(REG_SPARE_2, 10'd1023);
        write_reg(REG_SPARE_3, 10'd0);
        @(posedge clk);
        gen_random(300);

        wait_idle();
        write_reg(REG_IMAGE_WIDTH, COORD_W'($urandom_range(1, 640)));
        write_reg(REG_IMAGE_HEIGHT, COORD_W'($urandom_range(100, 300)));
        @(posedge clk);
        calm = 1'b1;
        gen_random(500);

        wait_idle();
        repeat (10) @(negedge clk);
        if (expected_pixels.size() != 0)
        begin
            failures++;
            $display("%0t: expected %0d more pixel writes, got none", $time,
                     expected_pixels.size());
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cppd_pkg.sv
rtl/cppd_palette.sv
rtl/cppd_parser.sv
rtl/cppd_out.sv
rtl/column_post_picture_decoder.sv
test/tb_column_post_picture_decoder.sv
